FILE: src/address_region_table_unit_assert.svh
// ---------------------------------------------------------------------------
// address_region_table_unit_assert: assertion macros
// concurrent checks on the rising edge of clk, masked while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ADDRESS_REGION_TABLE_UNIT_ASSERT_SVH
`define ADDRESS_REGION_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define ART_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define ART_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define ART_ASSERT_IMP(label, ante, cons)
`define ART_ASSERT_NXT(label, ante, cons)
`endif

`endif

FILE: src/art_pkg.sv
// ---------------------------------------------------------------------------
// art_pkg
// shared types and constants of the address region table
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package art_pkg;

  localparam int PAGE_BITS   = 36;
  localparam int MAX_REGIONS = 32;
  localparam int IDX_W       = $clog2(MAX_REGIONS);
  localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
  localparam int RIGHTS_W    = 3;
  localparam int STATUS_W    = 3;
  localparam int QDEPTH      = 2;

  // first-fit limit after reset: 2^35
  localparam logic [PAGE_BITS-1:0] SPACE_END_RST = PAGE_BITS'(64'h8_0000_0000);
  // register byte offsets
  localparam logic [3:0] ADDR_SPACE_END = 4'h0;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_RANGE  = 2'd2,
    OP_REMOVE = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_DENIED   = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_FULL     = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_TRY,
    ENG_FIT,
    ENG_LOOK,
    ENG_RSTART,
    ENG_RNEXT,
    ENG_REMOVE
  } eng_state_t;

  // classified request as queued between front and back
  typedef struct packed {
    op_t                 op;
    logic [PAGE_BITS-1:0] page;
    logic [PAGE_BITS-1:0] pages;
    logic                fixed;
    logic [RIGHTS_W-1:0] rights;
    logic [PAGE_BITS:0]  req_end;  // page + pages
    logic                try_ok;   // explicit base worth trying
  } req_t;

  // head of the request queue
  typedef struct packed {
    logic valid;
    req_t req;
  } q_head_t;

  typedef struct packed {
    logic [PAGE_BITS-1:0] base;
    logic [PAGE_BITS-1:0] len;
    logic [RIGHTS_W-1:0]  rights;
  } entry_t;

  typedef struct packed {
    status_t              status;
    logic [PAGE_BITS-1:0] base;
    logic [PAGE_BITS-1:0] pages;
    logic                 last;
  } res_t;

endpackage

FILE: src/art_front.sv
// ---------------------------------------------------------------------------
// art_front
// takes requests, precomputes range end and try flag, queues them
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module art_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [art_pkg::PAGE_BITS-1:0] in_page,
  input  logic [art_pkg::PAGE_BITS-1:0] in_pages,
  input  logic                          in_fixed,
  input  logic [art_pkg::RIGHTS_W-1:0]  in_rights,
  input  logic                          pop,
  output art_pkg::q_head_t              head
);

  art_pkg::req_t                   mem_r [art_pkg::QDEPTH];
  art_pkg::req_t                   req_c;
  logic                            wr_ptr_r, wr_ptr_nxt;
  logic                            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                      cnt_r, cnt_nxt;
  logic                            push;
  logic [art_pkg::PAGE_BITS:0]     end_c;

  // classify the incoming request
  always_comb begin
    end_c         = {1'b0, in_page} + {1'b0, in_pages};
    req_c.op      = art_pkg::op_t'(in_opcode);
    req_c.page    = in_page;
    req_c.pages   = in_pages;
    req_c.fixed   = in_fixed;
    req_c.rights  = in_rights;
    req_c.req_end = end_c;
    req_c.try_ok  = (in_page != '0) &&
                    (end_c <= ((art_pkg::PAGE_BITS+1)'(1) << art_pkg::PAGE_BITS));
  end

  assign busy = (cnt_r == 2'(art_pkg::QDEPTH));
  assign push = start && !busy;

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= req_c;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.req   = mem_r[rd_ptr_r];

endmodule

FILE: src/art_engine.sv
// ---------------------------------------------------------------------------
// art_engine
// walks the ordered region table one entry a cycle and updates it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "address_region_table_unit_assert.svh"

module art_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  art_pkg::q_head_t              head,
  output logic                          pop,
  input  logic [art_pkg::PAGE_BITS-1:0] space_end,
  output logic                          out_valid,
  output art_pkg::res_t                 res
);

  localparam int PB = art_pkg::PAGE_BITS;
  localparam int CW = art_pkg::CNT_W;
  localparam int NR = art_pkg::MAX_REGIONS;

  art_pkg::eng_state_t state_r, state_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  art_pkg::req_t       req_r, req_nxt;
  logic [PB:0]         cand_r, cand_nxt;
  logic [PB+1:0]       cand_end_r, cand_end_nxt;
  logic [PB:0]         next_r, next_nxt;
  logic                out_valid_r, out_valid_nxt;
  art_pkg::res_t       res_r, res_nxt;
  art_pkg::entry_t     tab_r [NR];
  art_pkg::entry_t     tab_nxt [NR];

  logic                ins_en, rem_en;
  logic [CW-1:0]       ins_pos, rem_pos;
  art_pkg::entry_t     ins_entry;

  art_pkg::entry_t     cur;
  logic                at_end;
  logic [PB:0]         rb, re;
  logic                rights_ok;
  logic                fit_skip;

  // current entry of the walk
  always_comb begin
    at_end    = (idx_r == count_r);
    cur       = tab_r[idx_r[art_pkg::IDX_W-1:0]];
    rb        = {1'b0, cur.base};
    re        = rb + {1'b0, cur.len};
    rights_ok = ((cur.rights & req_r.rights) == req_r.rights);
    fit_skip  = ((cand_r >= rb) && (cand_r < re)) ||
                ((cand_end_r > {1'b0, rb}) && (cand_end_r <= {1'b0, re})) ||
                ((cand_r < rb) && (cand_end_r > {1'b0, re}));
  end

  assign pop = head.valid && (state_r == art_pkg::ENG_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    req_nxt       = req_r;
    cand_nxt      = cand_r;
    cand_end_nxt  = cand_end_r;
    next_nxt      = next_r;
    out_valid_nxt = 1'b0;
    res_nxt       = '{status: art_pkg::ST_MISS, base: '0, pages: '0, last: 1'b1};
    ins_en        = 1'b0;
    ins_pos       = idx_r;
    ins_entry     = '{base: cand_r[PB-1:0], len: req_r.pages, rights: req_r.rights};
    rem_en        = 1'b0;
    rem_pos       = idx_r;

    unique case (state_r)
      art_pkg::ENG_IDLE: begin
        if (pop) begin
          req_nxt      = head.req;
          idx_nxt      = '0;
          cand_nxt     = (PB+1)'(1);
          cand_end_nxt = (PB+2)'(1) + (PB+2)'(head.req.pages);
          next_nxt     = {1'b0, head.req.page};
          unique case (head.req.op)
            art_pkg::OP_ALLOC: begin
              if (count_r == CW'(NR)) begin
                out_valid_nxt  = 1'b1;
                res_nxt.status = art_pkg::ST_FULL;
              end else if (head.req.pages == '0) begin
                out_valid_nxt  = 1'b1;
                res_nxt.status = art_pkg::ST_NO_SPACE;
              end else if (head.req.try_ok) begin
                state_nxt = art_pkg::ENG_TRY;
              end else if (!head.req.fixed) begin
                state_nxt = art_pkg::ENG_FIT;
              end else begin
                out_valid_nxt  = 1'b1;
                res_nxt.status = art_pkg::ST_NO_SPACE;
              end
            end
            art_pkg::OP_LOOKUP: state_nxt = art_pkg::ENG_LOOK;
            art_pkg::OP_RANGE:  state_nxt = art_pkg::ENG_RSTART;
            art_pkg::OP_REMOVE: state_nxt = art_pkg::ENG_REMOVE;
            default:            state_nxt = art_pkg::ENG_IDLE;
          endcase
        end
      end

      // placement at the requested base
      art_pkg::ENG_TRY: begin
        ins_entry.base = req_r.page;
        if (at_end || (re > {1'b0, req_r.page} && rb >= req_r.req_end)) begin
          ins_en        = 1'b1;
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: art_pkg::ST_OK, base: req_r.page,
                            pages: req_r.pages, last: 1'b1};
          state_nxt     = art_pkg::ENG_IDLE;
        end else if (re <= {1'b0, req_r.page}) begin
          idx_nxt = idx_r + CW'(1);
        end else if (!req_r.fixed) begin
          idx_nxt   = '0;
          state_nxt = art_pkg::ENG_FIT;
        end else begin
          out_valid_nxt  = 1'b1;
          res_nxt.status = art_pkg::ST_NO_SPACE;
          state_nxt      = art_pkg::ENG_IDLE;
        end
      end

      // first fit from page one
      art_pkg::ENG_FIT: begin
        if (at_end) begin
          state_nxt     = art_pkg::ENG_IDLE;
          out_valid_nxt = 1'b1;
          if (cand_end_r < {2'b00, space_end}) begin
            ins_en    = 1'b1;
            count_nxt = count_r + CW'(1);
            res_nxt   = '{status: art_pkg::ST_OK, base: cand_r[PB-1:0],
                          pages: req_r.pages, last: 1'b1};
          end else begin
            res_nxt.status = art_pkg::ST_NO_SPACE;
          end
        end else if ({1'b0, rb} >= cand_end_r) begin
          ins_en        = 1'b1;
          count_nxt     = count_r + CW'(1);
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: art_pkg::ST_OK, base: cand_r[PB-1:0],
                            pages: req_r.pages, last: 1'b1};
          state_nxt     = art_pkg::ENG_IDLE;
        end else begin
          if (fit_skip) begin
            cand_nxt     = re;
            cand_end_nxt = {1'b0, re} + (PB+2)'(req_r.pages);
          end
          idx_nxt = idx_r + CW'(1);
        end
      end

      // region holding the page
      art_pkg::ENG_LOOK: begin
        if (at_end) begin
          out_valid_nxt = 1'b1;
          state_nxt     = art_pkg::ENG_IDLE;
        end else if (({1'b0, req_r.page} >= rb) && ({1'b0, req_r.page} < re)) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: art_pkg::ST_OK, base: cur.base,
                            pages: cur.len, last: 1'b1};
          state_nxt     = art_pkg::ENG_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // first covering region of a range
      art_pkg::ENG_RSTART: begin
        if (at_end || rb > next_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = art_pkg::ENG_IDLE;
        end else if (re > next_r) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: art_pkg::ST_OK, base: cur.base,
                            pages: cur.len, last: 1'b1};
          state_nxt     = art_pkg::ENG_IDLE;
          if (!rights_ok) begin
            res_nxt.status = art_pkg::ST_DENIED;
          end else if (re < req_r.req_end) begin
            res_nxt.last = 1'b0;
            next_nxt     = re;
            idx_nxt      = idx_r + CW'(1);
            state_nxt    = art_pkg::ENG_RNEXT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // contiguous continuation of a range
      art_pkg::ENG_RNEXT: begin
        if (at_end || rb > next_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = art_pkg::ENG_IDLE;
        end else if (rb == next_r) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: art_pkg::ST_OK, base: cur.base,
                            pages: cur.len, last: 1'b1};
          state_nxt     = art_pkg::ENG_IDLE;
          if (!rights_ok) begin
            res_nxt.status = art_pkg::ST_DENIED;
          end else if (re < req_r.req_end) begin
            res_nxt.last = 1'b0;
            next_nxt     = re;
            idx_nxt      = idx_r + CW'(1);
            state_nxt    = art_pkg::ENG_RNEXT;
          end
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      // delete by base
      art_pkg::ENG_REMOVE: begin
        if (at_end) begin
          out_valid_nxt = 1'b1;
          state_nxt     = art_pkg::ENG_IDLE;
        end else if (cur.base == req_r.page) begin
          rem_en        = 1'b1;
          count_nxt     = count_r - CW'(1);
          out_valid_nxt = 1'b1;
          res_nxt       = '{status: art_pkg::ST_OK, base: cur.base,
                            pages: cur.len, last: 1'b1};
          state_nxt     = art_pkg::ENG_IDLE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end

      default: state_nxt = art_pkg::ENG_IDLE;
    endcase
  end

  // per-entry shift for insert and remove
  for (genvar g = 0; g < NR; g++) begin : g_ent
    art_pkg::entry_t prev_e, succ_e;
    if (g == 0) begin : g_first
      assign prev_e = ins_entry;
    end else begin : g_mid
      assign prev_e = tab_r[g-1];
    end
    if (g == NR - 1) begin : g_lastent
      assign succ_e = tab_r[g];
    end else begin : g_inner
      assign succ_e = tab_r[g+1];
    end
    always_comb begin
      tab_nxt[g] = tab_r[g];
      if (ins_en && (CW'(g) == ins_pos)) begin
        tab_nxt[g] = ins_entry;
      end else if (ins_en && (CW'(g) > ins_pos)) begin
        tab_nxt[g] = prev_e;
      end else if (rem_en && (CW'(g) >= rem_pos)) begin
        tab_nxt[g] = succ_e;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NR; j++) begin
      tab_r[j] <= tab_nxt[j];
    end
    req_r      <= req_nxt;
    cand_r     <= cand_nxt;
    cand_end_r <= cand_end_nxt;
    next_r     <= next_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= art_pkg::ENG_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign res       = res_r;

  // checks
  `ART_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CW'(NR))
  `ART_ASSERT_IMP(a_fail_is_last, out_valid_r && (res_r.status != art_pkg::ST_OK), res_r.last)
  `ART_ASSERT_NXT(a_range_continues, out_valid_r && !res_r.last, out_valid_r)
  `ART_ASSERT_IMP(a_pop_when_idle, pop, state_r == art_pkg::ENG_IDLE)

endmodule

FILE: src/address_region_table_unit.sv
// ---------------------------------------------------------------------------
// address_region_table_unit
// base-ordered table of page regions: allocate, lookup, range check, remove
// ---------------------------------------------------------------------------
// requests enter on start while busy is low; a two-deep queue holds them
// until the table engine is free, so busy rises only when both slots fill.
// results leave on out_valid for one cycle each and must be taken then.
// the engine walks the table one entry per cycle; a first fit that
// follows a failed explicit try walks it again from the first entry.
// insert and remove shift the entries from the decided position on in
// the cycle that decides them; the table holds at most 32 regions.
// a range check gives one result per cycle for each covering region,
// the final one marked by out_last.
// space_end_page sits at byte address 0 of the apb port, 36 bits wide
// in a 64-bit word; write it only while no request is outstanding.
// reset empties the table and sets space_end_page to 2^35; table entry
// storage itself is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module address_region_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_opcode,
  input  logic [art_pkg::PAGE_BITS-1:0] in_page,
  input  logic [art_pkg::PAGE_BITS-1:0] in_pages,
  input  logic                          in_fixed,
  input  logic [art_pkg::RIGHTS_W-1:0]  in_rights,
  output logic                          out_valid,
  output logic [art_pkg::STATUS_W-1:0]  out_status,
  output logic [art_pkg::PAGE_BITS-1:0] out_region_base,
  output logic [art_pkg::PAGE_BITS-1:0] out_region_pages,
  output logic                          out_last,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [3:0]                    paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);

  logic [art_pkg::PAGE_BITS-1:0] space_end_r, space_end_nxt;
  art_pkg::q_head_t              head;
  logic                          pop;
  art_pkg::res_t                 res;

  // configuration register
  assign pready = 1'b1;

  always_comb begin
    space_end_nxt = space_end_r;
    if (psel && penable && pwrite && (paddr == art_pkg::ADDR_SPACE_END)) begin
      space_end_nxt = pwdata[art_pkg::PAGE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      space_end_r <= art_pkg::SPACE_END_RST;
    end else begin
      space_end_r <= space_end_nxt;
    end
  end

  assign prdata = (paddr == art_pkg::ADDR_SPACE_END) ?
                  {{(64-art_pkg::PAGE_BITS){1'b0}}, space_end_r} : '0;

  // request intake and queue
  art_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_opcode (in_opcode),
    .in_page   (in_page),
    .in_pages  (in_pages),
    .in_fixed  (in_fixed),
    .in_rights (in_rights),
    .pop       (pop),
    .head      (head)
  );

  // table walk and update
  art_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .space_end (space_end_r),
    .out_valid (out_valid),
    .res       (res)
  );

  assign out_status       = res.status;
  assign out_region_base  = res.base;
  assign out_region_pages = res.pages;
  assign out_last         = res.last;

endmodule
